// File: sv/ranked_query_title_matcher_unit_macros.svh
// Assertion macros shared by the checker of the ranked query/title matcher.
`ifndef RANKED_QUERY_TITLE_MATCHER_UNIT_MACROS_SVH
`define RANKED_QUERY_TITLE_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RQTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqtm assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RQTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqtm assertion failed");

`endif

// File: sv/rqtm_pkg.sv
// Shared constants, types and helpers for the ranked query/title matcher.
package rqtm_pkg;

  localparam int QUERY_MAX = 64;
  localparam int TITLE_MAX = 127;
  localparam int IDX_W     = $clog2(QUERY_MAX);
  localparam int LEN_W     = $clog2(QUERY_MAX + 1);
  localparam int POS_W     = $clog2(TITLE_MAX + 1);

  // func codes
  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_TITLE = 1'b1;

  // rank codes
  localparam logic [1:0] RANK_PREFIX = 2'd0;
  localparam logic [1:0] RANK_WORD   = 2'd1;
  localparam logic [1:0] RANK_INSIDE = 2'd2;
  localparam logic [1:0] RANK_NONE   = 2'd3;

  // match vector bit order: 0 prefix, 1 word start, 2 anywhere
  localparam int MV_PREFIX = 0;
  localparam int MV_WORD   = 1;
  localparam int MV_ANY    = 2;

  // broadcast from control to every cell
  typedef struct packed {
    logic             q_wr;    // store q_byte into cell q_idx
    logic [IDX_W-1:0] q_idx;
    logic [7:0]       q_byte;
    logic             t_step;  // shift the match vectors by one title byte
    logic [7:0]       t_byte;
    logic [LEN_W-1:0] m;       // active query length
    logic             clear;   // drop title state
  } cell_cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'd65) && (b <= 8'd90)) ? b + 8'd32 : b;
  endfunction

endpackage

// File: sv/rqtm_cell.sv
// One query position: stored query byte and its three shift-and match bits.
module rqtm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  rqtm_pkg::cell_cmd_t       cmd,
  input  logic [rqtm_pkg::IDX_W-1:0] cell_index,
  input  logic [2:0]                carry_in,
  output logic [2:0]                carry_out,
  output logic [2:0]                hit
);
  import rqtm_pkg::*;

  logic [7:0] q_char;
  logic [2:0] vec;
  logic [2:0] vec_next;
  logic       mask;
  logic       is_top;

  assign mask     = (q_char == cmd.t_byte) && ({1'b0, cell_index} < cmd.m);
  assign is_top   = (({1'b0, cell_index} + LEN_W'(1)) == cmd.m);
  assign vec_next = carry_in & {3{mask}};
  assign carry_out = vec;
  assign hit      = vec_next & {3{is_top && cmd.t_step}};

  always_ff @(posedge clk) begin
    if (cmd.q_wr && (cmd.q_idx == cell_index)) begin
      q_char <= cmd.q_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec <= '0;
    end else if (cmd.clear) begin
      vec <= '0;
    end else if (cmd.t_step) begin
      vec <= vec_next;
    end
  end

endmodule

// File: sv/ranked_query_title_matcher_unit.sv
// Top level of the ranked query/title matcher: query loading, title control, cell row.
//
// Query bytes (func = 0) are trimmed of leading and trailing whitespace
// (bytes 9..13 and 32), lower-cased and written one per item into a row of
// 64 cells; title bytes (func = 1) are lower-cased and broadcast to every
// cell, where each cell compares its stored query byte and takes the prefix,
// word-start and anywhere match bits from its left neighbor (bit-parallel
// shift-and), so one item is accepted every clock cycle while in_ready is high,
// with no gaps between queries and titles. Only the first 127 bytes of a title
// count. The item with last = 1 of a title yields one match_rank two-bit code
// in the cycle after it is accepted: 0 title starts with the query (or the
// query is empty), 1 a word of the title starts with it, 2 it lies inside,
// 3 no match. A query item drops any title in progress; a title sent while a
// query is still loading uses the part loaded so far. Results sit in a single
// output register; in_ready falls only while that register holds a result that
// out_ready has not yet taken. No clearing pass after reset: query bytes are
// read only at positions written by the current query.
module ranked_query_title_matcher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] byte_value,
  input  logic       has_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] match_rank
);
  import rqtm_pkg::*;

  // query load state
  logic [LEN_W-1:0] query_length, query_length_next;
  logic [LEN_W-1:0] trimmed_length, trimmed_length_next;
  logic             leading_skipped, leading_skipped_next;
  // title state
  logic [POS_W-1:0] title_position, title_position_next;
  logic             previous_was_space, previous_was_space_next;
  logic [2:0]       found_flags, found_flags_next;
  // output register
  logic             out_valid_next;
  logic [1:0]       match_rank_next;

  logic       acc, q_step, t_item, q_take, q_room, t_active, t_adv;
  logic [7:0] lc;
  logic       ws;
  logic [2:0] carry0;
  logic [2:0] hit_any;
  logic [2:0] found_now;
  logic [LEN_W-1:0] tl_base;
  cell_cmd_t  cmd;

  logic [2:0] cell_vec [QUERY_MAX];
  logic [2:0] cell_hit [QUERY_MAX];

  // output register drains or is empty: take the next item
  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign q_step   = acc && (func == FUNC_QUERY);
  assign t_item   = acc && (func == FUNC_TITLE);

  assign lc = to_lower(byte_value);
  assign ws = is_ws(byte_value);

  // leading whitespace of a query is dropped before anything is stored
  assign q_take   = q_step && has_byte && !(!leading_skipped && ws);
  assign q_room   = query_length < LEN_W'(QUERY_MAX);
  assign t_active = t_item && has_byte && (title_position < POS_W'(TITLE_MAX));
  assign t_adv    = t_active && (trimmed_length != '0);

  always_comb begin
    cmd        = '0;
    cmd.q_wr   = q_take && q_room;
    cmd.q_idx  = query_length[IDX_W-1:0];
    cmd.q_byte = lc;
    cmd.t_step = t_adv;
    cmd.t_byte = lc;
    cmd.m      = trimmed_length;
    cmd.clear  = q_step || (t_item && last);
  end

  // carry into position 0: prefix only at title start, word after whitespace
  always_comb begin
    carry0            = '0;
    carry0[MV_PREFIX] = (title_position == '0);
    carry0[MV_WORD]   = (title_position != '0) && previous_was_space;
    carry0[MV_ANY]    = 1'b1;
  end

  for (genvar j = 0; j < QUERY_MAX; j++) begin : g_cell
    rqtm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cell_index (IDX_W'(j)),
      .carry_in   ((j == 0) ? carry0 : cell_vec[(j == 0) ? 0 : j - 1]),
      .carry_out  (cell_vec[j]),
      .hit        (cell_hit[j])
    );
  end

  // only the cell at position m-1 can report a full match
  always_comb begin
    hit_any = '0;
    for (int k = 0; k < QUERY_MAX; k++) begin
      hit_any = hit_any | cell_hit[k];
    end
  end

  assign found_now = found_flags | hit_any;

  always_comb begin
    query_length_next       = query_length;
    trimmed_length_next     = trimmed_length;
    leading_skipped_next    = leading_skipped;
    title_position_next     = title_position;
    previous_was_space_next = previous_was_space;
    found_flags_next        = found_flags;
    out_valid_next          = out_valid && !out_ready;
    match_rank_next         = match_rank;
    tl_base                 = (query_length == '0 && !leading_skipped) ? '0 : trimmed_length;

    if (q_step) begin
      trimmed_length_next     = tl_base;
      title_position_next     = '0;
      previous_was_space_next = 1'b0;
      found_flags_next        = '0;
      if (q_take) begin
        leading_skipped_next = 1'b1;
        if (q_room) begin
          query_length_next = query_length + LEN_W'(1);
          if (!ws) begin
            trimmed_length_next = query_length + LEN_W'(1);
          end
        end else if (!ws) begin
          trimmed_length_next = LEN_W'(QUERY_MAX);
        end
      end
      if (last) begin
        query_length_next    = '0;
        leading_skipped_next = 1'b0;
      end
    end else if (t_item) begin
      found_flags_next = found_now;
      if (t_active) begin
        previous_was_space_next = ws;
        title_position_next     = title_position + POS_W'(1);
      end
      if (last) begin
        out_valid_next          = 1'b1;
        title_position_next     = '0;
        previous_was_space_next = 1'b0;
        found_flags_next        = '0;
        if (trimmed_length == '0 || found_now[MV_PREFIX]) begin
          match_rank_next = RANK_PREFIX;
        end else if (found_now[MV_WORD]) begin
          match_rank_next = RANK_WORD;
        end else if (found_now[MV_ANY]) begin
          match_rank_next = RANK_INSIDE;
        end else begin
          match_rank_next = RANK_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length       <= '0;
      trimmed_length     <= '0;
      leading_skipped    <= 1'b0;
      title_position     <= '0;
      previous_was_space <= 1'b0;
      found_flags        <= '0;
      out_valid          <= 1'b0;
    end else begin
      query_length       <= query_length_next;
      trimmed_length     <= trimmed_length_next;
      leading_skipped    <= leading_skipped_next;
      title_position     <= title_position_next;
      previous_was_space <= previous_was_space_next;
      found_flags        <= found_flags_next;
      out_valid          <= out_valid_next;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    match_rank <= match_rank_next;
  end

endmodule

// File: sv/rqtm_checker.sv
// Port-level checks for the ranked query/title matcher, bound to the top level.
`include "ranked_query_title_matcher_unit_macros.svh"

module rqtm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       func,
  input logic [7:0] byte_value,
  input logic       has_byte,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] match_rank
);
  import rqtm_pkg::*;

  logic title_end;
  assign title_end = in_valid && in_ready && (func == FUNC_TITLE) && last;

  // a stalled result holds its rank
  `RQTM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(match_rank))
  // every title end yields a result next cycle
  `RQTM_ASSERT_NXT(a_title_result, title_end, out_valid)
  // a fresh result comes only from an accepted title end
  `RQTM_ASSERT_IMP(a_no_spurious, $rose(out_valid), $past(title_end))
  // input stalls only behind an untaken result
  `RQTM_ASSERT_IMP(a_ready_stall, !in_ready, out_valid && !out_ready)

endmodule

bind ranked_query_title_matcher_unit rqtm_checker u_rqtm_checker (.*);
